FILE: hw/rtl/ijs_pkg.sv
// shared types and constants for the i2c master job sequencer
`timescale 1ns / 1ps

package ijs_pkg;

  localparam int IDX_W = 7;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam logic [IDX_W-1:0] IDX_NONE = 7'h7F;
  localparam logic [7:0] SUBADDR_NONE = 8'hFF;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_MODE = 2'd3;

  // request kinds on tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVENT = 1'b1;

  typedef enum logic [1:0] {
    ADDR_NONE = 2'd0,
    ADDR_TX = 2'd1,
    ADDR_RX = 2'd2
  } addr_cmd_t;

  typedef enum logic [1:0] {
    CTL_KEEP = 2'd0,
    CTL_ENABLE = 2'd1,
    CTL_DISABLE = 2'd2
  } ctl_cmd_t;

  typedef enum logic [1:0] {
    POS_KEEP = 2'd0,
    POS_CLEAR = 2'd1,
    POS_SET = 2'd2
  } pos_cmd_t;

  typedef struct packed {
    logic start_sent;
    logic addr_sent;
    logic transfer_done;
    logic rx_ready;
    logic tx_empty;
    logic [7:0] rx_data;
    logic [7:0] rx_data_next;
  } event_t;

  typedef struct packed {
    logic gen_start;
    logic gen_stop;
    addr_cmd_t send_address;
    ctl_cmd_t ack_ctrl;
    pos_cmd_t pos_ctrl;
    ctl_cmd_t buf_irq_ctrl;
    logic tx_valid;
    logic [7:0] tx_data;
    logic [1:0] rx_count;
    logic [7:0] rx_first;
    logic [7:0] rx_second;
    logic job_done;
  } result_t;

  typedef struct packed {
    logic [IDX_W-1:0] byte_index_next;
    logic subaddr_done_next;
    logic wr_first;
    logic wr_second;
    logic [IDX_W-1:0] wr_first_idx;
    logic [IDX_W-1:0] wr_second_idx;
  } update_t;

  function automatic logic [M_DATA_W-1:0] pack_result(input result_t r);
    logic [M_DATA_W-1:0] d;
    d = '0;
    d[0] = r.gen_start;
    d[1] = r.gen_stop;
    d[3:2] = r.send_address;
    d[5:4] = r.ack_ctrl;
    d[7:6] = r.pos_ctrl;
    d[9:8] = r.buf_irq_ctrl;
    d[10] = r.tx_valid;
    d[18:11] = r.tx_data;
    d[20:19] = r.rx_count;
    d[28:21] = r.rx_first;
    d[36:29] = r.rx_second;
    d[37] = r.job_done;
    return d;
  endfunction

endpackage

FILE: hw/rtl/ijs_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module ijs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ijs_event_decode.sv
// status event decode: commands, result fields and next index state
`timescale 1ns / 1ps

module ijs_event_decode
  import ijs_pkg::*;
(
  input  event_t ev,
  input  logic [IDX_W-1:0] byte_index,
  input  logic subaddr_done,
  input  logic [7:0] buf_rdata,
  input  logic [7:0] sub_address,
  input  logic [5:0] byte_count,
  input  logic read_mode,
  output result_t res,
  output update_t upd
);

  logic [IDX_W-1:0] len;
  logic [IDX_W-1:0] idx_p1;
  logic [IDX_W-1:0] idx_p2;
  logic [IDX_W-1:0] idx_p3;
  logic [IDX_W-1:0] idx_p4;
  logic rd_phase;

  always_comb begin
    len = IDX_W'(byte_count);
    idx_p1 = byte_index + IDX_W'(1);
    idx_p2 = byte_index + IDX_W'(2);
    idx_p3 = byte_index + IDX_W'(3);
    idx_p4 = byte_index + IDX_W'(4);
    rd_phase = read_mode && subaddr_done;

    res = '0;
    upd = '0;
    upd.byte_index_next = byte_index;
    upd.subaddr_done_next = subaddr_done;
    upd.wr_first_idx = byte_index;
    upd.wr_second_idx = idx_p1;

    if (ev.start_sent) begin
      res.pos_ctrl = POS_CLEAR;
      res.ack_ctrl = CTL_ENABLE;
      upd.byte_index_next = '0;
      if (read_mode && (subaddr_done || sub_address == SUBADDR_NONE)) begin
        upd.subaddr_done_next = 1'b1;
        if (len == IDX_W'(2)) begin
          res.pos_ctrl = POS_SET;
        end
        res.send_address = ADDR_RX;
      end else begin
        res.send_address = ADDR_TX;
        // subaddress still to go: tx empty sends it first
        if (!subaddr_done) begin
          upd.byte_index_next = IDX_NONE;
        end
      end
    end else if (ev.addr_sent) begin
      if (rd_phase) begin
        case (len)
          IDX_W'(1): begin
            res.ack_ctrl = CTL_DISABLE;
            res.gen_stop = 1'b1;
            res.buf_irq_ctrl = CTL_ENABLE;
          end
          IDX_W'(2): begin
            res.ack_ctrl = CTL_DISABLE;
            res.buf_irq_ctrl = CTL_DISABLE;
          end
          IDX_W'(3): begin
            res.buf_irq_ctrl = CTL_DISABLE;
          end
          default: begin
            res.buf_irq_ctrl = CTL_ENABLE;
          end
        endcase
      end else begin
        res.buf_irq_ctrl = CTL_ENABLE;
      end
    end else if (ev.transfer_done) begin
      if (rd_phase) begin
        res.gen_stop = 1'b1;
        res.rx_count = 2'd2;
        res.rx_first = ev.rx_data;
        res.rx_second = ev.rx_data_next;
        upd.wr_first = 1'b1;
        upd.wr_second = 1'b1;
        if (len > IDX_W'(2)) begin
          res.ack_ctrl = CTL_DISABLE;
          res.buf_irq_ctrl = CTL_ENABLE;
          upd.byte_index_next = idx_p2;
        end else begin
          upd.byte_index_next = idx_p3;
        end
      end else if (subaddr_done || !read_mode) begin
        res.gen_stop = 1'b1;
        upd.byte_index_next = idx_p1;
      end else begin
        // subaddress sent for a read: repeated start
        res.gen_start = 1'b1;
        upd.subaddr_done_next = 1'b1;
      end
    end else if (ev.rx_ready) begin
      res.rx_count = 2'd1;
      res.rx_first = ev.rx_data;
      upd.wr_first = 1'b1;
      upd.byte_index_next = idx_p1;
      if (len == idx_p4) begin
        res.buf_irq_ctrl = CTL_DISABLE;
      end
      if (len == idx_p1) begin
        upd.byte_index_next = idx_p2;
      end
    end else if (ev.tx_empty) begin
      res.tx_valid = 1'b1;
      if (byte_index != IDX_NONE) begin
        res.tx_data = buf_rdata;
        upd.byte_index_next = idx_p1;
        if (len == idx_p1) begin
          res.buf_irq_ctrl = CTL_DISABLE;
        end
      end else begin
        upd.byte_index_next = '0;
        res.tx_data = sub_address;
        if (read_mode || len == '0) begin
          res.buf_irq_ctrl = CTL_DISABLE;
        end
      end
    end

    // completion check runs on every event, flagged or not
    if (upd.byte_index_next == len + IDX_W'(1)) begin
      upd.subaddr_done_next = 1'b0;
      res.job_done = 1'b1;
    end
  end

endmodule

FILE: hw/rtl/i2c_master_job_sequencer_unit.sv
// top level of the i2c master job sequencer
`timescale 1ns / 1ps

// Sequences one I2C master job (register write, or register read with a
// repeated start) from peripheral status events. Each request on the slave
// stream is either a write-buffer load (tuser 0) or a status event (tuser 1)
// and yields exactly one result on the master stream, in the cycle after it
// is accepted. A request is taken every cycle while the output register is
// free or being drained; the one exception is a two-byte receive event,
// which writes both bytes into the job buffer and holds off the next request
// while the second byte is written, because the buffer RAM has a single
// write port. The job buffer is a BUF_DEPTH-entry RAM read ahead at the
// index the next request will see, with a forwarding register for a write
// to the entry being read. It is not cleared after reset: a write job must
// load every byte it sends. The seven-bit slave address register is applied
// by the peripheral driver outside this block; writes to it are accepted and have no effect here.
module i2c_master_job_sequencer_unit
  import ijs_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // buf_index, buf_data, flag_start_sent, flag_addr_sent, flag_transfer_done,
  // flag_rx_ready, flag_tx_empty, rx_data, rx_data_next, zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // req_type
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // gen_start, gen_stop, send_address, ack_ctrl, pos_ctrl, buf_irq_ctrl,
  // tx_valid, tx_data, rx_count, rx_first, rx_second, job_done, zero fill
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1;

  // configuration
  logic [7:0] sub_address;
  logic [5:0] byte_count;
  logic read_mode;

  // job state
  logic [IDX_W-1:0] byte_index;
  logic subaddr_done;

  // second received byte waiting for the write port
  logic pend_valid;
  logic [AW-1:0] pend_addr;
  logic [7:0] pend_data;

  // buffer ram and forwarding
  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0] ram_rdata;
  logic fwd_hit;
  logic [7:0] fwd_data;
  logic [7:0] buf_rdata;

  logic [AW-1:0] addr_lut [IDX_SPAN];

  logic accept;
  logic is_event;
  logic load_in_range;
  logic [4:0] in_buf_index;
  logic [7:0] in_buf_data;
  event_t ev;
  result_t res;
  update_t upd;
  logic [IDX_W-1:0] idx_ahead;

  // index pattern to buffer position, folded at elaboration
  for (genvar g = 0; g < IDX_SPAN; g++) begin : g_lut
    assign addr_lut[g] = AW'(g % BUF_DEPTH);
  end

  assign in_buf_index = s_tdata[4:0];
  assign in_buf_data = s_tdata[12:5];
  assign ev.start_sent = s_tdata[13];
  assign ev.addr_sent = s_tdata[14];
  assign ev.transfer_done = s_tdata[15];
  assign ev.rx_ready = s_tdata[16];
  assign ev.tx_empty = s_tdata[17];
  assign ev.rx_data = s_tdata[25:18];
  assign ev.rx_data_next = s_tdata[33:26];

  assign s_tready = (!m_tvalid || m_tready) && !pend_valid;
  assign accept = s_tvalid && s_tready;
  assign is_event = (s_tuser == REQ_EVENT);
  assign load_in_range = 9'(in_buf_index) < 9'(BUF_DEPTH);
  assign buf_rdata = fwd_hit ? fwd_data : ram_rdata;

  ijs_event_decode u_decode (
    .ev           (ev),
    .byte_index   (byte_index),
    .subaddr_done (subaddr_done),
    .buf_rdata    (buf_rdata),
    .sub_address  (sub_address),
    .byte_count   (byte_count),
    .read_mode    (read_mode),
    .res          (res),
    .upd          (upd)
  );

  // write port: pending byte first, then loads, then received bytes
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = pend_data;
    if (pend_valid) begin
      ram_we = 1'b1;
    end else if (accept && !is_event) begin
      ram_we = load_in_range;
      ram_waddr = AW'(in_buf_index);
      ram_wdata = in_buf_data;
    end else if (accept && upd.wr_first) begin
      ram_we = 1'b1;
      ram_waddr = addr_lut[upd.wr_first_idx];
      ram_wdata = ev.rx_data;
    end
  end

  // read ahead at the index the next request will see
  assign idx_ahead = (accept && is_event) ? upd.byte_index_next : byte_index;
  assign ram_raddr = addr_lut[idx_ahead];

  ijs_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_address <= SUBADDR_NONE;
      byte_count <= '0;
      read_mode <= 1'b0;
      byte_index <= '0;
      subaddr_done <= 1'b0;
      pend_valid <= 1'b0;
      fwd_hit <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SUB_ADDRESS: sub_address <= cfg_data;
          REG_BYTE_COUNT: byte_count <= cfg_data[5:0];
          REG_READ_MODE: read_mode <= cfg_data[0];
          default: begin
            // slave address is used by the peripheral driver only
          end
        endcase
      end

      if (accept && is_event) begin
        byte_index <= upd.byte_index_next;
        subaddr_done <= upd.subaddr_done_next;
      end

      if (pend_valid) begin
        pend_valid <= 1'b0;
      end else if (accept && is_event && upd.wr_second) begin
        pend_valid <= 1'b1;
      end

      fwd_hit <= ram_we && (ram_waddr == ram_raddr);

      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!pend_valid) begin
      pend_addr <= addr_lut[upd.wr_second_idx];
      pend_data <= ev.rx_data_next;
    end
    fwd_data <= ram_wdata;
    if (accept) begin
      m_tdata <= is_event ? pack_result(res) : '0;
    end
  end

endmodule

FILE: test/i2c_master_job_sequencer_unit_tb.sv
// self-checking testbench for the i2c master job sequencer top level
`timescale 1ns / 1ps

module i2c_master_job_sequencer_unit_tb;
  import ijs_pkg::*;

  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW = $clog2(BUF_DEPTH);
  localparam int ITEM_TARGET = 2000;
  localparam int IDLE_PCT = 21;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 50;

  // status flag positions, highest priority first
  localparam int EV_START = 0;
  localparam int EV_ADDR = 1;
  localparam int EV_BTF = 2;
  localparam int EV_RXNE = 3;
  localparam int EV_TXE = 4;

  typedef struct packed {
    logic kind;
    logic [4:0] buf_index;
    logic [7:0] buf_data;
    logic [4:0] flags;
    logic [7:0] rx_byte;
    logic [7:0] rx_byte_next;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [7:0] cfg_subaddr = SUBADDR_NONE;
  logic [5:0] cfg_count = '0;
  logic cfg_read_job = 1'b0;
  logic [IDX_W-1:0] job_index = '0;
  logic subaddr_sent = 1'b0;
  logic [7:0] job_buf [BUF_DEPTH];

  request_t req_backlog[$];
  result_t due_results[$];
  request_t on_bus;
  result_t want;
  int items_queued = 0;
  int results_seen = 0;
  int fails = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit perturb = 1'b0;
  int quiet_cycles = 0;
  wire calm = (results_seen >= 800) && (results_seen < 1300);

  i2c_master_job_sequencer_unit #(
    .BUF_DEPTH(BUF_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t sequencer_response(request_t rq);
    result_t r;
    logic [IDX_W-1:0] len;
    logic rd;
    r = '0;
    len = {1'b0, cfg_count};
    rd = cfg_read_job;
    if (rq.kind == REQ_LOAD) begin
      job_buf[rq.buf_index] = rq.buf_data;
      return r;
    end
    if (rq.flags[EV_START]) begin
      r.pos_ctrl = POS_CLEAR;
      r.ack_ctrl = CTL_ENABLE;
      job_index = '0;
      if (rd && (subaddr_sent || cfg_subaddr == SUBADDR_NONE)) begin
        subaddr_sent = 1'b1;
        if (len == 7'd2) r.pos_ctrl = POS_SET;
        r.send_address = ADDR_RX;
      end else begin
        r.send_address = ADDR_TX;
        if (!subaddr_sent) job_index = IDX_NONE;
      end
    end else if (rq.flags[EV_ADDR]) begin
      r.buf_irq_ctrl = CTL_ENABLE;
      if (rd && subaddr_sent) begin
        if (len == 7'd1) begin
          r.ack_ctrl = CTL_DISABLE;
          r.gen_stop = 1'b1;
        end else if (len == 7'd2) begin
          r.ack_ctrl = CTL_DISABLE;
          r.buf_irq_ctrl = CTL_DISABLE;
        end else if (len == 7'd3) begin
          r.buf_irq_ctrl = CTL_DISABLE;
        end
      end
    end else if (rq.flags[EV_BTF]) begin
      if (rd && subaddr_sent) begin
        r.gen_stop = 1'b1;
        r.rx_count = 2'd2;
        r.rx_first = rq.rx_byte;
        r.rx_second = rq.rx_byte_next;
        job_buf[BUF_AW'(job_index % BUF_DEPTH)] = rq.rx_byte;
        job_index = job_index + 7'd1;
        job_buf[BUF_AW'(job_index % BUF_DEPTH)] = rq.rx_byte_next;
        job_index = job_index + 7'd1;
        if (len > 7'd2) begin
          r.ack_ctrl = CTL_DISABLE;
          r.buf_irq_ctrl = CTL_ENABLE;
        end else begin
          job_index = job_index + 7'd1;
        end
      end else if (subaddr_sent || !rd) begin
        r.gen_stop = 1'b1;
        job_index = job_index + 7'd1;
      end else begin
        r.gen_start = 1'b1;
        subaddr_sent = 1'b1;
      end
    end else if (rq.flags[EV_RXNE]) begin
      r.rx_count = 2'd1;
      r.rx_first = rq.rx_byte;
      job_buf[BUF_AW'(job_index % BUF_DEPTH)] = rq.rx_byte;
      job_index = job_index + 7'd1;
      if (len == job_index + 7'd3) r.buf_irq_ctrl = CTL_DISABLE;
      if (len == job_index) job_index = job_index + 7'd1;
    end else if (rq.flags[EV_TXE]) begin
      r.tx_valid = 1'b1;
      if (job_index != IDX_NONE) begin
        r.tx_data = job_buf[BUF_AW'(job_index % BUF_DEPTH)];
        job_index = job_index + 7'd1;
        if (len == job_index) r.buf_irq_ctrl = CTL_DISABLE;
      end else begin
        // first transmit of the job carries the subaddress
        job_index = '0;
        r.tx_data = cfg_subaddr;
        if (rd || len == 7'd0) r.buf_irq_ctrl = CTL_DISABLE;
      end
    end
    if (job_index == len + 7'd1) begin
      subaddr_sent = 1'b0;
      r.job_done = 1'b1;
    end
    return r;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    rq.kind = 1'($urandom_range(1));
    rq.buf_index = 5'($urandom_range(31));
    rq.buf_data = 8'($urandom_range(255));
    rq.flags = 5'($urandom_range(31));
    rq.rx_byte = 8'($urandom_range(255));
    rq.rx_byte_next = 8'($urandom_range(255));
    return rq;
  endfunction

  function automatic void check_field(string name, int unsigned exp_val, int unsigned got);
    if (exp_val != got) begin
      if (fails < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, exp_val, got);
      fails++;
    end
  endfunction

  task automatic add_event(int which);
    request_t rq;
    // stray requests and lost events break up the job flow now and then
    if (perturb && $urandom_range(99) < 6) begin
      req_backlog.push_back(random_request());
      items_queued++;
    end
    if (perturb && $urandom_range(99) < 2) return;
    rq = random_request();
    rq.kind = REQ_EVENT;
    rq.flags = 5'd1 << which;
    if (perturb && $urandom_range(99) < 10)
      rq.flags = rq.flags | (5'($urandom_range(31)) & ~((5'd2 << which) - 5'd1));
    req_backlog.push_back(rq);
    items_queued++;
  endtask

  task automatic queue_job();
    if (!cfg_read_job) begin
      add_event(EV_START);
      add_event(EV_ADDR);
      add_event(EV_TXE);
      repeat (cfg_count) add_event(EV_TXE);
      add_event(EV_BTF);
    end else begin
      if (cfg_subaddr != SUBADDR_NONE) begin
        add_event(EV_START);
        add_event(EV_ADDR);
        add_event(EV_TXE);
        add_event(EV_BTF);
      end
      add_event(EV_START);
      add_event(EV_ADDR);
      if (cfg_count == 6'd2) begin
        add_event(EV_BTF);
      end else if (cfg_count < 6'd2) begin
        add_event(EV_RXNE);
      end else begin
        repeat (cfg_count - 3) add_event(EV_RXNE);
        add_event(EV_BTF);
        add_event(EV_RXNE);
      end
    end
  endtask

  // sampled away from the rising edge so the driver's decision is settled
  task automatic wait_idle();
    while (req_backlog.size() != 0 || s_tvalid || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_SUB_ADDRESS: cfg_subaddr = val;
      REG_BYTE_COUNT: cfg_count = val[5:0];
      REG_READ_MODE: cfg_read_job = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [6:0] tgt, logic [7:0] sub, logic [5:0] cnt, logic rd);
    wait_idle();
    write_reg(REG_TARGET_ADDRESS, {1'b0, tgt});
    write_reg(REG_SUB_ADDRESS, sub);
    write_reg(REG_BYTE_COUNT, {2'b00, cnt});
    write_reg(REG_READ_MODE, {7'b0, rd});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // request driver, predicts each request as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) due_results.push_back(sequencer_response(on_bus));
      if (!s_tvalid || s_tready) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = req_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= on_bus.kind;
          s_tdata <= {{(S_DATA_W - 34){1'b0}}, on_bus.rx_byte_next, on_bus.rx_byte,
                      on_bus.flags, on_bus.buf_data, on_bus.buf_index};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          if (fails < MAX_REPORTS) $error("result %h arrived with nothing expected", m_tdata);
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("gen_start", want.gen_start, m_tdata[0]);
          check_field("gen_stop", want.gen_stop, m_tdata[1]);
          check_field("send_address", want.send_address, m_tdata[3:2]);
          check_field("ack_ctrl", want.ack_ctrl, m_tdata[5:4]);
          check_field("pos_ctrl", want.pos_ctrl, m_tdata[7:6]);
          check_field("buf_irq_ctrl", want.buf_irq_ctrl, m_tdata[9:8]);
          check_field("tx_valid", want.tx_valid, m_tdata[10]);
          check_field("tx_data", want.tx_data, m_tdata[18:11]);
          check_field("rx_count", want.rx_count, m_tdata[20:19]);
          check_field("rx_first", want.rx_first, m_tdata[28:21]);
          check_field("rx_second", want.rx_second, m_tdata[36:29]);
          check_field("job_done", want.job_done, m_tdata[37]);
        end
      end
      // one long back-pressure stretch while requests keep coming
      if (!hold_done && results_seen > 300 && req_backlog.size() > 8) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    request_t rq;
    int unsigned pick;
    logic [6:0] tgt;
    logic [7:0] sub;
    logic [5:0] cnt;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every buffer entry holds a value before a job can send it
    for (int i = 0; i < BUF_DEPTH; i++) begin
      rq = random_request();
      rq.kind = REQ_LOAD;
      rq.buf_index = i[4:0];
      req_backlog.push_back(rq);
    end

    // read without subaddress, two bytes through the POS path
    set_config(7'd127, SUBADDR_NONE, 6'd2, 1'b1);
    queue_job();
    rq = random_request();
    rq.kind = REQ_EVENT;
    rq.flags = '0;
    req_backlog.push_back(rq);
    rq.flags = '1;
    req_backlog.push_back(rq);
    // zero-length write still sends the subaddress
    set_config(7'd0, 8'h00, 6'd0, 1'b0);
    queue_job();
    rq = random_request();
    rq.kind = REQ_LOAD;
    rq.buf_index = 5'd0;
    rq.buf_data = 8'hFF;
    req_backlog.push_back(rq);
    rq.buf_index = 5'd31;
    rq.buf_data = 8'h00;
    req_backlog.push_back(rq);
    // single-byte read behind a subaddress phase
    set_config(7'd85, 8'h5A, 6'd1, 1'b1);
    queue_job();

    perturb = 1'b1;
    while (items_queued < ITEM_TARGET) begin
      pick = $urandom_range(3);
      tgt = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom_range(127));
      pick = $urandom_range(9);
      sub = (pick < 3) ? SUBADDR_NONE : (pick == 3) ? 8'h00 : 8'($urandom_range(255));
      pick = $urandom_range(19);
      if (pick <= 5) cnt = pick[5:0];
      else if (pick == 6) cnt = 6'd32;
      else if (pick == 7) cnt = 6'($urandom_range(63, 33));
      else cnt = 6'($urandom_range(32));
      set_config(tgt, sub, cnt, 1'($urandom_range(1)));
      repeat ($urandom_range(3, 1)) queue_job();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fails == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
